@@ design/impulse_collision_resolver_2d_top_macros.svh @@
// Assertion macros for the 2D impulse collision resolver.
// Included by the top level; no other dependencies.
`ifndef IMPULSE_COLLISION_RESOLVER_2D_TOP_MACROS_SVH
`define IMPULSE_COLLISION_RESOLVER_2D_TOP_MACROS_SVH

// Same-cycle implication.
`define ICR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icr: same-cycle check failed");

// Next-cycle implication.
`define ICR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icr: next-cycle check failed");

`endif

@@ design/icr_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 2D impulse resolver.
// No dependencies; every other .sv design file uses it by scoped names.
`default_nettype none

package icr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int E_BITS    = 16;
   localparam logic [16:0] E_ONE = 17'h10000;
   // Normalized normal: larger magnitude has its top bit here.
   localparam int NORM_MSB  = 29;
   // Square-root iterations and quotient bits of the dividers.
   localparam int SQ_STEPS  = 31;
   localparam int Q_BITS    = 17;

   localparam logic signed [36:0] SAT_MAX = 37'sh00_7FFF_FFFF;
   localparam logic signed [36:0] SAT_MIN = 37'sh1F_8000_0000;

   typedef struct packed {
      logic                        func;
      logic signed [WORD_BITS-1:0] vel_ax;
      logic signed [WORD_BITS-1:0] vel_ay;
      logic signed [WORD_BITS-1:0] vel_bx;
      logic signed [WORD_BITS-1:0] vel_by;
      logic [WORD_BITS-1:0]        mass_a;
      logic [WORD_BITS-1:0]        mass_b;
      logic [16:0]                 elast_a;
      logic [16:0]                 elast_b;
      logic signed [WORD_BITS-1:0] normal_x;
      logic signed [WORD_BITS-1:0] normal_y;
   } icr_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] new_vel_ax;
      logic signed [WORD_BITS-1:0] new_vel_ay;
      logic signed [WORD_BITS-1:0] new_vel_bx;
      logic signed [WORD_BITS-1:0] new_vel_by;
      logic                        degenerate;
   } icr_rsp_type;

   // Contact data that rides along the pipeline.
   typedef struct packed {
      logic                        func;
      logic signed [WORD_BITS-1:0] vel_ax;
      logic signed [WORD_BITS-1:0] vel_ay;
      logic signed [WORD_BITS-1:0] vel_bx;
      logic signed [WORD_BITS-1:0] vel_by;
      logic [WORD_BITS-1:0]        mass_b;
      logic [WORD_BITS:0]          mass_sum;
      logic [16:0]                 elast_a;
      logic [16:0]                 elast_b;
      logic                        nx_neg;
      logic                        ny_neg;
      logic                        degen;
   } icr_side_type;

   // Payload carried through the square-root unit.
   typedef struct packed {
      icr_side_type side;
      logic [NORM_MSB:0] mxn;
      logic [NORM_MSB:0] myn;
   } icr_sqpay_type;

   // Sign-magnitude product shifted back by 16 with rounding half away from zero.
   function automatic logic signed [39:0] mul_round(input logic signed [39:0] a,
                                                    input logic signed [18:0] b);
      logic [39:0] ma;
      logic [18:0] mb;
      logic [58:0] prod;
      logic [39:0] q;
      ma = a[39] ? 40'(-a) : 40'(a);
      mb = b[18] ? 19'(-b) : 19'(b);
      prod = 59'(ma) * 59'(mb);
      q = 40'((prod + (59'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      return (a[39] ^ b[18]) ? -signed'(q) : signed'(q);
   endfunction

   // Saturate a wide sum to the signed word range.
   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [36:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[WORD_BITS-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/icr_norm.sv @@
// Normal scaling: magnitudes, leading-one search, power-of-two shift, squares.
// Depends on icr_pkg.
`default_nettype none

module icr_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  icr_pkg::icr_side_type  in_side,
   input  logic signed [31:0]     in_nx,
   input  logic signed [31:0]     in_ny,
   output logic                   out_valid,
   output icr_pkg::icr_sqpay_type out_pay,
   output logic [60:0]            out_sumsq
);
   localparam int DEPTH = 5;

   logic [DEPTH-1:0]      valid_ff;
   icr_pkg::icr_side_type side_ff [DEPTH];
   logic [31:0] mx1_in, my1_in, m1_in;
   logic [31:0] mx1_ff, my1_ff, m1_ff, mx2_ff, my2_ff;
   logic [4:0]  p2_in, p2_ff;
   logic [29:0] mxn3_in, myn3_in;
   logic [29:0] mxn3_ff, myn3_ff, mxn4_ff, myn4_ff, mxn5_ff, myn5_ff;
   logic [59:0] sqx4_ff, sqy4_ff;
   logic [60:0] sum5_ff;

   // Component magnitudes and the larger of the two.
   assign mx1_in = in_nx[31] ? 32'(-in_nx) : 32'(in_nx);
   assign my1_in = in_ny[31] ? 32'(-in_ny) : 32'(in_ny);
   assign m1_in  = (mx1_in > my1_in) ? mx1_in : my1_in;

   // Position of the leading one of the larger magnitude.
   always_comb begin
      p2_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (m1_ff[i]) p2_in = 5'(i);
      end
   end

   // Bring the leading one to the target bit; right shifts truncate.
   always_comb begin
      if (p2_ff > 5'(icr_pkg::NORM_MSB)) begin
         mxn3_in = 30'(mx2_ff >> (p2_ff - 5'(icr_pkg::NORM_MSB)));
         myn3_in = 30'(my2_ff >> (p2_ff - 5'(icr_pkg::NORM_MSB)));
      end else begin
         mxn3_in = 30'(mx2_ff << (5'(icr_pkg::NORM_MSB) - p2_ff));
         myn3_in = 30'(my2_ff << (5'(icr_pkg::NORM_MSB) - p2_ff));
      end
   end

   // Valid bits of the five stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   // Data registers of the five stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < DEPTH; i++) side_ff[i] <= side_ff[i-1];
         mx1_ff  <= mx1_in;
         my1_ff  <= my1_in;
         m1_ff   <= m1_in;
         mx2_ff  <= mx1_ff;
         my2_ff  <= my1_ff;
         p2_ff   <= p2_in;
         mxn3_ff <= mxn3_in;
         myn3_ff <= myn3_in;
         mxn4_ff <= mxn3_ff;
         myn4_ff <= myn3_ff;
         sqx4_ff <= 60'(mxn3_ff) * 60'(mxn3_ff);
         sqy4_ff <= 60'(myn3_ff) * 60'(myn3_ff);
         mxn5_ff <= mxn4_ff;
         myn5_ff <= myn4_ff;
         sum5_ff <= 61'(sqx4_ff) + 61'(sqy4_ff);
      end
   end

   assign out_valid    = valid_ff[DEPTH-1];
   assign out_pay.side = side_ff[DEPTH-1];
   assign out_pay.mxn  = mxn5_ff;
   assign out_pay.myn  = myn5_ff;
   assign out_sumsq    = sum5_ff;

endmodule

`default_nettype wire

@@ design/icr_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on icr_pkg.
`default_nettype none

module icr_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  icr_pkg::icr_sqpay_type in_pay,
   input  logic [60:0]            in_x,
   output logic                   out_valid,
   output icr_pkg::icr_sqpay_type out_pay,
   output logic [30:0]            out_len
);
   localparam int STEPS = icr_pkg::SQ_STEPS;

   logic [61:0]            xs [STEPS+1];
   logic [61:0]            rs [STEPS+1];
   logic                   vs [STEPS+1];
   icr_pkg::icr_sqpay_type ps [STEPS+1];

   assign xs[0] = 62'(in_x);
   assign rs[0] = '0;
   assign vs[0] = in_valid;
   assign ps[0] = in_pay;

   // One digit-by-digit step per stage, trial bit falling by a factor of four each time.
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic [61:0] TRIAL_BIT = 62'(1) << (2 * (STEPS - 1 - s));
      logic [61:0] trial;
      logic [61:0] x_ff, r_ff;
      logic        valid_ff;
      icr_pkg::icr_sqpay_type pay_ff;

      assign trial = rs[s] + TRIAL_BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= vs[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pay_ff <= ps[s];
            if (xs[s] >= trial) begin
               x_ff <= xs[s] - trial;
               r_ff <= (rs[s] >> 1) + TRIAL_BIT;
            end else begin
               x_ff <= xs[s];
               r_ff <= rs[s] >> 1;
            end
         end
      end

      assign xs[s+1] = x_ff;
      assign rs[s+1] = r_ff;
      assign vs[s+1] = valid_ff;
      assign ps[s+1] = pay_ff;
   end

   assign out_valid = vs[STEPS];
   assign out_pay   = ps[STEPS];
   assign out_len   = rs[STEPS][30:0];

endmodule

`default_nettype wire

@@ design/icr_recip.sv @@
// Three pipelined restoring dividers: unit normal components and mass ratio.
// Depends on icr_pkg.
`default_nettype none

module icr_recip (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  icr_pkg::icr_sqpay_type in_pay,
   input  logic [30:0]            in_len,
   output logic                   out_valid,
   output icr_pkg::icr_side_type  out_side,
   output logic [16:0]            out_ux,
   output logic [16:0]            out_uy,
   output logic [16:0]            out_ra
);
   localparam int QB = icr_pkg::Q_BITS;

   logic [47:0]           remx [QB+1];
   logic [47:0]           remy [QB+1];
   logic [49:0]           remr [QB+1];
   logic [30:0]           du   [QB+1];
   logic [32:0]           dr   [QB+1];
   logic [QB-1:0]         qx   [QB+1];
   logic [QB-1:0]         qy   [QB+1];
   logic [QB-1:0]         qr   [QB+1];
   logic                  vs   [QB+1];
   icr_pkg::icr_side_type ss   [QB+1];

   logic                  prep_valid_ff;
   logic [47:0]           prep_nx_ff, prep_ny_ff;
   logic [49:0]           prep_nr_ff;
   logic [30:0]           prep_du_ff;
   logic [32:0]           prep_dr_ff;
   icr_pkg::icr_side_type prep_side_ff;

   // Rounded numerators: value scaled by 2^16 plus half the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_nx_ff   <= (48'(in_pay.mxn) << icr_pkg::FRAC_BITS) + 48'(in_len >> 1);
         prep_ny_ff   <= (48'(in_pay.myn) << icr_pkg::FRAC_BITS) + 48'(in_len >> 1);
         prep_nr_ff   <= (50'(in_pay.side.mass_b) << icr_pkg::E_BITS)
                         + 50'(in_pay.side.mass_sum >> 1);
         prep_du_ff   <= in_len;
         prep_dr_ff   <= in_pay.side.mass_sum;
         prep_side_ff <= in_pay.side;
      end
   end

   assign remx[0] = prep_nx_ff;
   assign remy[0] = prep_ny_ff;
   assign remr[0] = prep_nr_ff;
   assign du[0]   = prep_du_ff;
   assign dr[0]   = prep_dr_ff;
   assign qx[0]   = '0;
   assign qy[0]   = '0;
   assign qr[0]   = '0;
   assign vs[0]   = prep_valid_ff;
   assign ss[0]   = prep_side_ff;

   // One quotient bit per stage, most significant first.
   for (genvar s = 1; s <= QB; s++) begin : g_step
      localparam int QPOS = QB - s;
      logic [47:0] tux;
      logic [49:0] tur;
      logic        hx, hy, hr;
      logic [47:0] remx_ff, remy_ff;
      logic [49:0] remr_ff;
      logic [30:0] du_ff;
      logic [32:0] dr_ff;
      logic [QB-1:0] qx_ff, qy_ff, qr_ff;
      logic        valid_ff;
      icr_pkg::icr_side_type side_ff;

      assign tux = 48'(du[s-1]) << QPOS;
      assign tur = 50'(dr[s-1]) << QPOS;
      assign hx  = remx[s-1] >= tux;
      assign hy  = remy[s-1] >= tux;
      assign hr  = remr[s-1] >= tur;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= vs[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            remx_ff <= hx ? remx[s-1] - tux : remx[s-1];
            remy_ff <= hy ? remy[s-1] - tux : remy[s-1];
            remr_ff <= hr ? remr[s-1] - tur : remr[s-1];
            qx_ff   <= qx[s-1] | (QB'(hx) << QPOS);
            qy_ff   <= qy[s-1] | (QB'(hy) << QPOS);
            qr_ff   <= qr[s-1] | (QB'(hr) << QPOS);
            du_ff   <= du[s-1];
            dr_ff   <= dr[s-1];
            side_ff <= ss[s-1];
         end
      end

      assign remx[s] = remx_ff;
      assign remy[s] = remy_ff;
      assign remr[s] = remr_ff;
      assign du[s]   = du_ff;
      assign dr[s]   = dr_ff;
      assign qx[s]   = qx_ff;
      assign qy[s]   = qy_ff;
      assign qr[s]   = qr_ff;
      assign vs[s]   = valid_ff;
      assign ss[s]   = side_ff;
   end

   assign out_valid = vs[QB];
   assign out_side  = ss[QB];
   assign out_ux    = qx[QB];
   assign out_uy    = qy[QB];
   assign out_ra    = qr[QB];

endmodule

`default_nettype wire

@@ design/icr_impulse.sv @@
// Impulse arithmetic: dot product, impulse scaling, velocity update, saturation.
// Depends on icr_pkg.
`default_nettype none

module icr_impulse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  icr_pkg::icr_side_type in_side,
   input  logic [16:0]           in_ux,
   input  logic [16:0]           in_uy,
   input  logic [16:0]           in_ra,
   output logic                  out_valid,
   output icr_pkg::icr_rsp_type  out_rsp
);
   localparam int DEPTH = 7;

   logic [DEPTH-1:0]      valid_ff;
   icr_pkg::icr_side_type side_ff [DEPTH];

   logic signed [17:0] uxp, uyp;
   logic [33:0]        ee;
   logic signed [17:0] ux1_in, uy1_in;
   logic [17:0]        k1_in;
   logic signed [32:0] dx1_in, dy1_in;

   logic signed [17:0] ux1_ff, uy1_ff, ux2_ff, uy2_ff, ux3_ff, uy3_ff;
   logic signed [17:0] ux4_ff, uy4_ff, ux5_ff, uy5_ff;
   logic [16:0]        ra1_ff, rb1_ff, ra2_ff, rb2_ff, ra3_ff, rb3_ff, ra4_ff, rb4_ff;
   logic [17:0]        k1_ff, k2_ff, k3_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic signed [33:0] px2_ff, py2_ff;
   logic signed [34:0] d3_ff;
   logic signed [35:0] g4_ff;
   logic signed [35:0] ga5_ff, gb5_ff;
   logic signed [35:0] tax6_ff, tay6_ff, tbx6_ff, tby6_ff;
   icr_pkg::icr_rsp_type rsp7_in, rsp7_ff;

   // Signed unit normal, restitution factor and velocity difference.
   assign uxp    = signed'({1'b0, in_ux});
   assign uyp    = signed'({1'b0, in_uy});
   assign ux1_in = in_side.nx_neg ? -uxp : uxp;
   assign uy1_in = in_side.ny_neg ? -uyp : uyp;
   assign ee     = 34'(in_side.elast_a) * 34'(in_side.elast_b) + 34'(32768);
   assign k1_in  = in_side.func ? 18'(icr_pkg::E_ONE) + 18'(in_side.elast_a)
                                : 18'(icr_pkg::E_ONE) + ee[33:16];
   assign dx1_in = in_side.func ? 33'(in_side.vel_ax) : 33'(in_side.vel_bx) - 33'(in_side.vel_ax);
   assign dy1_in = in_side.func ? 33'(in_side.vel_ay) : 33'(in_side.vel_by) - 33'(in_side.vel_ay);

   // Final sums, saturation and pass-through for degenerate or static cases.
   always_comb begin
      logic signed [36:0] nax, nay, nbx, nby;
      icr_pkg::icr_side_type sd;
      sd  = side_ff[DEPTH-2];
      nax = 37'(sd.vel_ax) + 37'(tax6_ff);
      nay = 37'(sd.vel_ay) + 37'(tay6_ff);
      nbx = 37'(sd.vel_bx) - 37'(tbx6_ff);
      nby = 37'(sd.vel_by) - 37'(tby6_ff);
      rsp7_in.degenerate = sd.degen;
      if (sd.degen) begin
         rsp7_in.new_vel_ax = sd.vel_ax;
         rsp7_in.new_vel_ay = sd.vel_ay;
         rsp7_in.new_vel_bx = sd.vel_bx;
         rsp7_in.new_vel_by = sd.vel_by;
      end else begin
         rsp7_in.new_vel_ax = icr_pkg::sat_word(nax);
         rsp7_in.new_vel_ay = icr_pkg::sat_word(nay);
         if (sd.func) begin
            rsp7_in.new_vel_bx = sd.vel_bx;
            rsp7_in.new_vel_by = sd.vel_by;
         end else begin
            rsp7_in.new_vel_bx = icr_pkg::sat_word(nbx);
            rsp7_in.new_vel_by = icr_pkg::sat_word(nby);
         end
      end
   end

   // Valid bits of the seven stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   // Data registers; at most one multiply level per stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < DEPTH; i++) side_ff[i] <= side_ff[i-1];
         ux1_ff <= ux1_in;
         uy1_ff <= uy1_in;
         ra1_ff <= in_ra;
         rb1_ff <= icr_pkg::E_ONE - in_ra;
         k1_ff  <= k1_in;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;

         ux2_ff <= ux1_ff;
         uy2_ff <= uy1_ff;
         ra2_ff <= ra1_ff;
         rb2_ff <= rb1_ff;
         k2_ff  <= k1_ff;
         px2_ff <= 34'(icr_pkg::mul_round(40'(dx1_ff), 19'(ux1_ff)));
         py2_ff <= 34'(icr_pkg::mul_round(40'(dy1_ff), 19'(uy1_ff)));

         ux3_ff <= ux2_ff;
         uy3_ff <= uy2_ff;
         ra3_ff <= ra2_ff;
         rb3_ff <= rb2_ff;
         k3_ff  <= k2_ff;
         d3_ff  <= 35'(px2_ff) + 35'(py2_ff);

         ux4_ff <= ux3_ff;
         uy4_ff <= uy3_ff;
         ra4_ff <= ra3_ff;
         rb4_ff <= rb3_ff;
         g4_ff  <= 36'(icr_pkg::mul_round(40'(d3_ff), signed'({1'b0, k3_ff})));

         // Static surface: the full impulse goes to body A with reversed sign.
         ux5_ff <= ux4_ff;
         uy5_ff <= uy4_ff;
         if (side_ff[3].func) begin
            ga5_ff <= -g4_ff;
         end else begin
            ga5_ff <= 36'(icr_pkg::mul_round(40'(g4_ff), signed'({2'b00, ra4_ff})));
         end
         gb5_ff <= 36'(icr_pkg::mul_round(40'(g4_ff), signed'({2'b00, rb4_ff})));

         tax6_ff <= 36'(icr_pkg::mul_round(40'(ga5_ff), 19'(ux5_ff)));
         tay6_ff <= 36'(icr_pkg::mul_round(40'(ga5_ff), 19'(uy5_ff)));
         tbx6_ff <= 36'(icr_pkg::mul_round(40'(gb5_ff), 19'(ux5_ff)));
         tby6_ff <= 36'(icr_pkg::mul_round(40'(gb5_ff), 19'(uy5_ff)));

         rsp7_ff <= rsp7_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_rsp   = rsp7_ff;

endmodule

`default_nettype wire

@@ design/impulse_collision_resolver_2d_top.sv @@
// Top level of the 2D impulse collision resolver: normal scaling, square root,
// dividers and impulse arithmetic in one stalling pipeline. Depends on icr_pkg.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  icr_pkg::icr_req_type
//   rsp       out        rsp_valid/rsp_stall  icr_pkg::icr_rsp_type
//
// One contact enters per cycle while the pipeline is not stalled; each passes
// through 5 scaling, 31 square-root, 18 divider and 7 arithmetic stages.
// Reset is synchronous and clears only the valid bits of the stages.
// A held result under rsp_stall freezes the whole pipeline, so req_stall
// follows it in the same cycle and no transfer is lost or repeated.
`default_nettype none
`include "impulse_collision_resolver_2d_top_macros.svh"

module impulse_collision_resolver_2d_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  icr_pkg::icr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output icr_pkg::icr_rsp_type rsp_data
);
   logic                   advance;
   icr_pkg::icr_side_type  side_in;
   logic                   norm_valid, sqrt_valid, recip_valid;
   icr_pkg::icr_sqpay_type norm_pay, sqrt_pay;
   logic [60:0]            norm_sumsq;
   logic [30:0]            sqrt_len;
   icr_pkg::icr_side_type  recip_side;
   logic [16:0]            recip_ux, recip_uy, recip_ra;

   // The pipeline moves unless a finished result is held back.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Contact data that travels beside the normal computation.
   always_comb begin
      side_in.func     = req_data.func;
      side_in.vel_ax   = req_data.vel_ax;
      side_in.vel_ay   = req_data.vel_ay;
      side_in.vel_bx   = req_data.vel_bx;
      side_in.vel_by   = req_data.vel_by;
      side_in.mass_b   = req_data.mass_b;
      side_in.mass_sum = 33'(req_data.mass_a) + 33'(req_data.mass_b);
      side_in.elast_a  = (req_data.elast_a > icr_pkg::E_ONE) ? icr_pkg::E_ONE : req_data.elast_a;
      side_in.elast_b  = (req_data.elast_b > icr_pkg::E_ONE) ? icr_pkg::E_ONE : req_data.elast_b;
      side_in.nx_neg   = req_data.normal_x[31];
      side_in.ny_neg   = req_data.normal_y[31];
      side_in.degen    = (req_data.normal_x == '0 && req_data.normal_y == '0)
                         || req_data.mass_a == '0
                         || (!req_data.func && req_data.mass_b == '0);
   end

   icr_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_side   (side_in),
      .in_nx     (req_data.normal_x),
      .in_ny     (req_data.normal_y),
      .out_valid (norm_valid),
      .out_pay   (norm_pay),
      .out_sumsq (norm_sumsq)
   );

   icr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (norm_valid),
      .in_pay    (norm_pay),
      .in_x      (norm_sumsq),
      .out_valid (sqrt_valid),
      .out_pay   (sqrt_pay),
      .out_len   (sqrt_len)
   );

   icr_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_pay    (sqrt_pay),
      .in_len    (sqrt_len),
      .out_valid (recip_valid),
      .out_side  (recip_side),
      .out_ux    (recip_ux),
      .out_uy    (recip_uy),
      .out_ra    (recip_ra)
   );

   icr_impulse u_impulse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (recip_valid),
      .in_side   (recip_side),
      .in_ux     (recip_ux),
      .in_uy     (recip_uy),
      .in_ra     (recip_ra),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   // Stall back-pressure comes only from a held result.
   `ICR_ASSERT_IMPL(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ICR_ASSERT_IMPL(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   // No result appears right after reset.
   `ICR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

`default_nettype wire
